// ===== src/rgbvp_pkg.sv =====
package rgbvp_pkg;

    // widths of the mask and of the decoded channel placement
    localparam int MASK_WIDTH = 32;
    localparam int CNT_W      = $clog2(MASK_WIDTH + 1);
    localparam int RSH_W      = 4;
    localparam int PIX_W      = 32;
    localparam int WIDE_W     = PIX_W + 8;
    localparam int CFG_IDX_W  = 3;

    // source layout codes
    localparam logic [2:0] CMD_RGB24 = 3'd0;
    localparam logic [2:0] CMD_BGR24 = 3'd1;
    localparam logic [2:0] CMD_RGB32 = 3'd2;
    localparam logic [2:0] CMD_BGR32 = 3'd3;
    localparam logic [2:0] CMD_GRAY  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RED_MASK   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_MASK = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_MASK  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_FOUR_BYTE  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_SWAP  = CFG_IDX_W'(4);

    // mask values after reset
    localparam logic [31:0] RED_MASK_RST   = 32'h0000_F800;
    localparam logic [31:0] GREEN_MASK_RST = 32'h0000_07E0;
    localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_001F;

    // one channel: value is (v >> rsh) << lsh
    typedef struct packed {
        logic [RSH_W-1:0] rsh;
        logic [CNT_W-1:0] lsh;
    } chan_shift_t;

    typedef struct packed {
        chan_shift_t red;
        chan_shift_t green;
        chan_shift_t blue;
        logic        four_byte;
        logic        byte_swap;
    } rgbvp_cfg_t;

    // turn a channel mask into right and left shift amounts
    function automatic chan_shift_t decode_mask(input logic [31:0] mask);
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] off;
        logic [CNT_W:0]   sum;
        chan_shift_t      res;
        cnt = '0;
        off = CNT_W'(MASK_WIDTH);
        for (int i = 0; i < MASK_WIDTH; i++) begin
            if (mask[i])
                cnt = cnt + CNT_W'(1);
        end
        for (int i = MASK_WIDTH - 1; i >= 0; i--) begin
            if (mask[i])
                off = CNT_W'(i);
        end
        sum = {1'b0, cnt} + {1'b0, off} - (CNT_W + 1)'(8);
        if (cnt > CNT_W'(8)) begin
            res.rsh = '0;
            res.lsh = sum[CNT_W-1:0];
        end
        else begin
            res.rsh = RSH_W'(8) - RSH_W'(cnt);
            res.lsh = off;
        end
        return res;
    endfunction

endpackage

// ===== src/rgbvp_if.sv =====
// source pixel channel
interface rgbvp_pixel_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic       last_in;

    modport source (output valid, command, byte0, byte1, byte2, byte3, last_in,
                    input ready);
    modport sink (input valid, command, byte0, byte1, byte2, byte3, last_in,
                  output ready);
endinterface

// packed pixel channel
interface rgbvp_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] packed_pixel;
    logic        last_out;

    modport source (output valid, packed_pixel, last_out, input ready);
    modport sink (input valid, packed_pixel, last_out, output ready);
endinterface

// configuration write channel
interface rgbvp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/rgb_to_visual_pixel_packer.sv =====
// Packs one 8-bit-per-channel source pixel per request into a display pixel
// word laid out by the red, green and blue masks. Pixels are taken one per
// clock unless back-pressure fills every stage; a result is offered once the
// three-stage datapath (layout select, channel shift, merge and byte swap)
// has loaded it into its last register. Back-pressure on the result side
// stalls the stages in turn, and the input keeps accepting while any stage
// has room. Configuration writes are always ready and take effect on the
// next cycle; each mask is decoded into shift amounts as it is written.
// Write configuration only while no pixel is in flight.
module rgb_to_visual_pixel_packer
    import rgbvp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    rgbvp_pixel_if.sink    pixel,
    rgbvp_result_if.source result,
    rgbvp_cfg_if.sink      cfg
);

    rgbvp_cfg_t cfg_q;

    rgbvp_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    // stage registers
    logic             s1_valid_reg;
    logic             s1_bad_reg;
    logic             s1_last_reg;
    logic [7:0]       s1_r_reg;
    logic [7:0]       s1_g_reg;
    logic [7:0]       s1_b_reg;
    logic             s2_valid_reg;
    logic             s2_bad_reg;
    logic             s2_last_reg;
    logic [PIX_W-1:0] s2_r_reg;
    logic [PIX_W-1:0] s2_g_reg;
    logic [PIX_W-1:0] s2_b_reg;
    logic             s3_valid_reg;
    logic             s3_last_reg;
    logic [PIX_W-1:0] s3_pix_reg;

    logic             s1_bad_next;
    logic [7:0]       s1_r_next;
    logic [7:0]       s1_g_next;
    logic [7:0]       s1_b_next;
    logic [PIX_W-1:0] s2_r_next;
    logic [PIX_W-1:0] s2_g_next;
    logic [PIX_W-1:0] s2_b_next;
    logic [PIX_W-1:0] s3_pix_next;
    logic [PIX_W-1:0] merged;
    logic [WIDE_W-1:0] r_wide;
    logic [WIDE_W-1:0] g_wide;
    logic [WIDE_W-1:0] b_wide;

    // a stage loads when it is empty or its content moves on
    logic ld1;
    logic ld2;
    logic ld3;

    assign ld3         = !s3_valid_reg || result.ready;
    assign ld2         = !s2_valid_reg || ld3;
    assign ld1         = !s1_valid_reg || ld2;
    assign pixel.ready = ld1;

    // stage 1: pick channels from the source layout
    always_comb
    begin
        s1_bad_next = 1'b0;
        s1_r_next   = '0;
        s1_g_next   = '0;
        s1_b_next   = '0;
        case (pixel.command)
            CMD_RGB24:
            begin
                s1_r_next = pixel.byte0;
                s1_g_next = pixel.byte1;
                s1_b_next = pixel.byte2;
            end
            CMD_BGR24:
            begin
                s1_r_next = pixel.byte2;
                s1_g_next = pixel.byte1;
                s1_b_next = pixel.byte0;
            end
            CMD_RGB32:
            begin
                s1_r_next = pixel.byte1;
                s1_g_next = pixel.byte2;
                s1_b_next = pixel.byte3;
            end
            CMD_BGR32:
            begin
                s1_r_next = pixel.byte3;
                s1_g_next = pixel.byte2;
                s1_b_next = pixel.byte1;
            end
            CMD_GRAY:
            begin
                s1_r_next = pixel.byte0;
                s1_g_next = pixel.byte0;
                s1_b_next = pixel.byte0;
            end
            default:
            begin
                s1_bad_next = 1'b1;
            end
        endcase
    end

    // stage 2: place each channel in its field
    always_comb
    begin
        r_wide    = {{(WIDE_W-8){1'b0}}, s1_r_reg >> cfg_q.red.rsh} << cfg_q.red.lsh;
        g_wide    = {{(WIDE_W-8){1'b0}}, s1_g_reg >> cfg_q.green.rsh} << cfg_q.green.lsh;
        b_wide    = {{(WIDE_W-8){1'b0}}, s1_b_reg >> cfg_q.blue.rsh} << cfg_q.blue.lsh;
        s2_r_next = r_wide[PIX_W-1:0];
        s2_g_next = g_wide[PIX_W-1:0];
        s2_b_next = b_wide[PIX_W-1:0];
    end

    // stage 3: merge, optional byte swap, cut to output size
    always_comb
    begin
        merged = s2_r_reg | s2_g_reg | s2_b_reg;
        if (cfg_q.four_byte)
        begin
            if (cfg_q.byte_swap)
                s3_pix_next = {merged[7:0], merged[15:8], merged[23:16], merged[31:24]};
            else
                s3_pix_next = merged;
        end
        else
        begin
            if (cfg_q.byte_swap)
                s3_pix_next = {16'b0, merged[7:0], merged[15:8]};
            else
                s3_pix_next = {16'b0, merged[15:0]};
        end
        if (s2_bad_reg)
            s3_pix_next = '0;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
                s1_valid_reg <= pixel.valid;
            if (ld2)
                s2_valid_reg <= s1_valid_reg;
            if (ld3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_bad_reg  <= s1_bad_next;
            s1_last_reg <= pixel.last_in;
            s1_r_reg    <= s1_r_next;
            s1_g_reg    <= s1_g_next;
            s1_b_reg    <= s1_b_next;
        end
        if (ld2)
        begin
            s2_bad_reg  <= s1_bad_reg;
            s2_last_reg <= s1_last_reg;
            s2_r_reg    <= s2_r_next;
            s2_g_reg    <= s2_g_next;
            s2_b_reg    <= s2_b_next;
        end
        if (ld3)
        begin
            s3_last_reg <= s2_last_reg;
            s3_pix_reg  <= s3_pix_next;
        end
    end

    assign result.valid        = s3_valid_reg;
    assign result.packed_pixel = s3_pix_reg;
    assign result.last_out     = s3_last_reg;

    // an accepted request always lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && pixel.ready |=> s1_valid_reg)
        else $error("accepted pixel lost at stage one");
    // an unknown layout leaves an all-zero pixel
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_bad_reg && ld3 |=> result.packed_pixel == '0)
        else $error("unknown layout gave a non-zero pixel");
    // two-byte mode keeps the upper half clear
    a_two_byte_upper: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !cfg_q.four_byte |-> result.packed_pixel[31:16] == 16'b0)
        else $error("upper half set in two-byte mode");
    // a full pipe with a stalled output takes no new request
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_valid_reg && s3_valid_reg && !result.ready |-> !pixel.ready)
        else $error("request taken while every stage is full");

endmodule

// ===== src/rgbvp_cfg_regs.sv =====
module rgbvp_cfg_regs
    import rgbvp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rgbvp_cfg_if.sink   cfg,
    output rgbvp_cfg_t  cfg_q
);

    rgbvp_cfg_t cfg_reg;
    rgbvp_cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    // masks are decoded on the write so items see ready-made shifts
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_RED_MASK:   cfg_next.red       = decode_mask(cfg.data);
                REG_GREEN_MASK: cfg_next.green     = decode_mask(cfg.data);
                REG_BLUE_MASK:  cfg_next.blue      = decode_mask(cfg.data);
                REG_FOUR_BYTE:  cfg_next.four_byte = cfg.data[0];
                REG_BYTE_SWAP:  cfg_next.byte_swap = cfg.data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red       <= decode_mask(RED_MASK_RST);
            cfg_reg.green     <= decode_mask(GREEN_MASK_RST);
            cfg_reg.blue      <= decode_mask(BLUE_MASK_RST);
            cfg_reg.four_byte <= 1'b0;
            cfg_reg.byte_swap <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // a channel never shifts past the mask or drops more than a byte
    a_red_lsh: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_reg.red.lsh <= CNT_W'(MASK_WIDTH))
        else $error("red left shift beyond mask width");
    a_rsh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_reg.red.rsh <= RSH_W'(8) && cfg_reg.green.rsh <= RSH_W'(8) &&
        cfg_reg.blue.rsh <= RSH_W'(8))
        else $error("right shift beyond eight bits");
    a_wide_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_reg.green.rsh == '0 |-> cfg_reg.green.lsh <= CNT_W'(MASK_WIDTH - 8))
        else $error("wide green field shifted beyond mask");

endmodule

// ===== verif/rgb_to_visual_pixel_packer_tb.sv =====
module rgb_to_visual_pixel_packer_tb;
    import rgbvp_pkg::*;

    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned BURST_PIXELS = 100;
    localparam int unsigned BURSTS       = 8;

    // one packed pixel as it should leave the block
    typedef struct packed {
        logic [31:0] pixel;
        logic        last;
    } packed_result_t;

    // holds the register copy, works out each packed pixel and checks results
    class packed_pixel_scoreboard;
        logic [31:0]    red_field_mask;
        logic [31:0]    green_field_mask;
        logic [31:0]    blue_field_mask;
        logic           wide_pixel;
        logic           swap_bytes;
        packed_result_t expected_pixels[$];
        int unsigned    mismatches;

        function new();
            red_field_mask   = RED_MASK_RST;
            green_field_mask = GREEN_MASK_RST;
            blue_field_mask  = BLUE_MASK_RST;
            wide_pixel       = 1'b0;
            swap_bytes       = 1'b0;
            mismatches       = 0;
        endfunction

        function void apply_register_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_RED_MASK:   red_field_mask = data;
                REG_GREEN_MASK: green_field_mask = data;
                REG_BLUE_MASK:  blue_field_mask = data;
                REG_FOUR_BYTE:  wide_pixel = data[0];
                REG_BYTE_SWAP:  swap_bytes = data[0];
                default: ;
            endcase
        endfunction

        // field width is the set bit count, offset the zeros below the lowest set bit
        function logic [63:0] shift_channel(logic [31:0] mask, logic [7:0] value);
            int unsigned width;
            int unsigned offset;
            logic [63:0] value_64;
            width    = $countones(mask);
            offset   = 32;
            value_64 = {56'h0, value};
            for (int i = 31; i >= 0; i--)
            begin
                if (mask[i])
                    offset = i;
            end
            if (width > 8)
                return value_64 << (width + offset - 8);
            return (value_64 >> (8 - width)) << offset;
        endfunction

        function logic [31:0] pack_pixel(logic [2:0] cmd, logic [7:0] b0, logic [7:0] b1,
                                         logic [7:0] b2, logic [7:0] b3);
            logic [7:0]  red;
            logic [7:0]  green;
            logic [7:0]  blue;
            logic [63:0] word;
            case (cmd)
                CMD_RGB24: begin red = b0; green = b1; blue = b2; end
                CMD_BGR24: begin red = b2; green = b1; blue = b0; end
                CMD_RGB32: begin red = b1; green = b2; blue = b3; end
                CMD_BGR32: begin red = b3; green = b2; blue = b1; end
                CMD_GRAY:  begin red = b0; green = b0; blue = b0; end
                default:   return '0;
            endcase
            word = shift_channel(red_field_mask, red) | shift_channel(green_field_mask, green)
                   | shift_channel(blue_field_mask, blue);
            // byte reversal over the output width
            if (swap_bytes)
            begin
                if (wide_pixel)
                    word = {32'h0, word[7:0], word[15:8], word[23:16], word[31:24]};
                else
                    word = {48'h0, word[7:0], word[15:8]};
            end
            return wide_pixel ? word[31:0] : {16'h0, word[15:0]};
        endfunction

        function void note_source_pixel(logic [2:0] cmd, logic [7:0] b0, logic [7:0] b1,
                                        logic [7:0] b2, logic [7:0] b3, logic last);
            packed_result_t res;
            res.pixel = pack_pixel(cmd, b0, b1, b2, b3);
            res.last  = last;
            expected_pixels.push_back(res);
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 30)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_packed_pixel(logic [31:0] pixel, logic last);
            packed_result_t exp;
            if (expected_pixels.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result pixel %h last %b", pixel, last));
                return;
            end
            exp = expected_pixels.pop_front();
            if (pixel !== exp.pixel)
                report_mismatch($sformatf("packed_pixel %h, expected %h", pixel, exp.pixel));
            if (last !== exp.last)
                report_mismatch($sformatf("last_out %b, expected %b", last, exp.last));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_token = 0;

    packed_pixel_scoreboard packer_sb = new();

    rgbvp_pixel_if  pixel_bus ();
    rgbvp_result_if result_bus ();
    rgbvp_cfg_if    cfg_bus ();

    rgb_to_visual_pixel_packer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    always #1 clk = ~clk;

    // one request per call, with random idle cycles ahead of it
    task automatic send_pixel(input logic [2:0] cmd, input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_bus.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_bus.valid   <= 1'b1;
        pixel_bus.command <= cmd;
        pixel_bus.byte0   <= b0;
        pixel_bus.byte1   <= b1;
        pixel_bus.byte2   <= b2;
        pixel_bus.byte3   <= b3;
        pixel_bus.last_in <= last;
        do
            @(posedge clk);
        while (pixel_bus.ready !== 1'b1);
        packer_sb.note_source_pixel(cmd, b0, b1, b2, b3, last);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (packer_sb.pending() != 0);
    endtask

    task automatic finish_burst();
        pixel_bus.valid <= 1'b0;
        wait_drained();
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        packer_sb.apply_register_write(idx, data);
    endtask

    task automatic write_config(input logic [31:0] red, input logic [31:0] green,
                                input logic [31:0] blue, input logic four, input logic swap);
        write_register(REG_RED_MASK, red);
        write_register(REG_GREEN_MASK, green);
        write_register(REG_BLUE_MASK, blue);
        write_register(REG_FOUR_BYTE, {31'h0, four});
        write_register(REG_BYTE_SWAP, {31'h0, swap});
        cfg_bus.valid <= 1'b0;
    endtask

    // empty, full, random or contiguous field masks
    function automatic logic [31:0] random_mask();
        int unsigned width;
        int unsigned offset;
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return $urandom();
            default:
            begin
                width  = $urandom_range(32, 1);
                offset = $urandom_range(32 - width);
                return 32'(((64'd1 << width) - 64'd1) << offset);
            end
        endcase
    endfunction

    // mostly real layouts, some unused codes
    function automatic logic [2:0] random_command();
        if ($urandom_range(99) < 85)
            return 3'($urandom_range(CMD_GRAY));
        return 3'($urandom_range(7, CMD_GRAY + 1));
    endfunction

    // result side: random stalls, and a long hold-off on request
    initial
    begin
        int unsigned hold_seen;
        hold_seen = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                result_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                result_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            packer_sb.check_packed_pixel(result_bus.packed_pixel, result_bus.last_out);
    end

    // stimulus
    initial
    begin
        logic [3:0] phase;
        rst_n             = 1'b0;
        pixel_bus.valid   = 1'b0;
        pixel_bus.command = CMD_RGB24;
        pixel_bus.byte0   = '0;
        pixel_bus.byte1   = '0;
        pixel_bus.byte2   = '0;
        pixel_bus.byte3   = '0;
        pixel_bus.last_in = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = REG_RED_MASK;
        cfg_bus.data      = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset layout, every source code including the unused ones
        for (int code = 0; code < 8; code++)
            send_pixel(3'(code), 8'hA5, 8'h3C, 8'h96, 8'h0F, 1'(code % 2));
        send_pixel(CMD_RGB32, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(CMD_BGR24, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        finish_burst();

        // full mask, empty mask, top bit only, 4-byte swap
        write_config(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 1'b1, 1'b1);
        for (int code = 0; code <= CMD_GRAY; code++)
            send_pixel(3'(code), 8'hFF, 8'h81, 8'h7E, 8'h01, 1'(code % 2));
        finish_burst();

        // red lands above 16 bits and is lost, 2-byte swap
        write_config(32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 1'b0, 1'b1);
        for (int code = 0; code <= CMD_GRAY; code++)
            send_pixel(3'(code), 8'h80, 8'h01, 8'hFE, 8'h7F, 1'(code % 2));
        finish_burst();

        // random bursts over the idling patterns and all mode pairs
        for (int k = 0; k < BURSTS; k++)
        begin
            phase = 4'(k);
            write_config(random_mask(), random_mask(), random_mask(), phase[0], phase[1]);
            case (phase[1:0])
                2'd0: begin send_idle_pct = 0;  stall_pct = 0;  end
                2'd1: begin send_idle_pct = 72; stall_pct = 0;  end
                2'd2: begin send_idle_pct = 0;  stall_pct = 72; end
                default: begin send_idle_pct = 25; stall_pct = 25; end
            endcase
            // long hold-off on the result side so the pipeline fills
            if (phase[1:0] == 2'd0)
                hold_token <= hold_token + 1;
            for (int i = 0; i < BURST_PIXELS; i++)
            begin
                // sender pause until every pending pixel is out
                if (phase == 4'd1 && i == BURST_PIXELS / 2)
                begin
                    pixel_bus.valid <= 1'b0;
                    wait_drained();
                end
                send_pixel(random_command(), 8'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom), 1'($urandom_range(1)));
            end
            finish_burst();
        end

        repeat (8) @(posedge clk);
        if (packer_sb.mismatches == 0)
            $display("rgb_to_visual_pixel_packer verification clean");
        else
            $display("rgb_to_visual_pixel_packer verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #1000000;
        $display("rgb_to_visual_pixel_packer verification failed");
        $finish;
    end

endmodule
